// ===== src/lctmw_pkg.sv =====
package lctmw_pkg;

	// Field widths
	localparam int unsigned RAW_W    = 24;
	localparam int unsigned DIFF_W   = 24;
	localparam int unsigned GAIN_W   = 24;
	localparam int unsigned WEIGHT_W = 24;
	localparam int unsigned PROD_W   = DIFF_W + GAIN_W;
	localparam int unsigned FRAC_DROP = 16;
	localparam int unsigned SUM_W    = 32;
	localparam int unsigned CNT_W    = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 24;

	// Batch limits
	localparam int unsigned MAX_BATCH_DEF = 255;
	localparam int unsigned MIN_BATCH     = 3;

	// Register reset values
	localparam logic [CNT_W-1:0]    BATCH_SIZE_RST  = 8'd10;
	localparam logic [RAW_W-1:0]    ZERO_OFFSET_RST = 24'd0;
	localparam logic [GAIN_W-1:0]   GAIN_RST        = 24'd41943;
	localparam logic [WEIGHT_W-1:0] FLOOR_RST       = 24'd0;
	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX      = 24'hFF_FFFF;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BATCH_SIZE  = 3'd0,
		REG_ZERO_OFFSET = 3'd1,
		REG_GAIN        = 3'd2,
		REG_FLOOR       = 3'd3,
		REG_CEILING     = 3'd4
	} cfg_reg_t;

endpackage

// ===== src/lctmw_mul.sv =====
module lctmw_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [lctmw_pkg::GAIN_W-1:0]        multiplicand,
	input  logic [lctmw_pkg::DIFF_W-1:0]        multiplier,
	output logic                                done,
	output logic [lctmw_pkg::PROD_W-1:0]        product
);

	localparam int unsigned CntW = $clog2(lctmw_pkg::DIFF_W);

	logic                              busy_q;
	logic                              done_q;
	logic [CntW-1:0]                   cnt_q;
	logic [lctmw_pkg::GAIN_W-1:0]      mcand_q;
	logic [lctmw_pkg::GAIN_W-1:0]      hi_q;
	logic [lctmw_pkg::DIFF_W-1:0]      lo_q;
	logic [lctmw_pkg::GAIN_W:0]        part_sum;
	logic                              last_bit;

	// Add the multiplicand when the low multiplier bit is set
	assign part_sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);
	assign last_bit = (cnt_q == CntW'(lctmw_pkg::DIFF_W - 1));

	// Sequence one multiplier bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_bit) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift the partial product right, retiring one multiplier bit
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= multiplicand;
			hi_q    <= '0;
			lo_q    <= multiplier;
		end else if (busy_q) begin
			hi_q <= part_sum[lctmw_pkg::GAIN_W:1];
			lo_q <= {part_sum[0], lo_q[lctmw_pkg::DIFF_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = {hi_q, lo_q};

endmodule

// ===== src/lctmw_div.sv =====
module lctmw_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [lctmw_pkg::SUM_W-1:0]        dividend,
	input  logic [lctmw_pkg::CNT_W-1:0]        divisor,
	output logic                               done,
	output logic [lctmw_pkg::SUM_W-1:0]        quotient
);

	localparam int unsigned CntW = $clog2(lctmw_pkg::SUM_W);

	logic                              busy_q;
	logic                              done_q;
	logic [CntW-1:0]                   cnt_q;
	logic [lctmw_pkg::CNT_W-1:0]       dvs_q;
	logic [lctmw_pkg::CNT_W-1:0]       rem_q;
	logic [lctmw_pkg::SUM_W-1:0]       quo_q;
	logic [lctmw_pkg::CNT_W:0]         trial;
	logic [lctmw_pkg::CNT_W:0]         trial_sub;
	logic                              q_bit;
	logic                              last_bit;

	// Bring down the next dividend bit and try the subtract
	assign trial     = {rem_q, quo_q[lctmw_pkg::SUM_W-1]};
	assign trial_sub = trial - {1'b0, dvs_q};
	assign q_bit     = (trial >= {1'b0, dvs_q});
	assign last_bit  = (cnt_q == CntW'(lctmw_pkg::SUM_W - 1));

	// Sequence one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_bit) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring step: remainder stays below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= q_bit ? trial_sub[lctmw_pkg::CNT_W-1:0] : trial[lctmw_pkg::CNT_W-1:0];
			quo_q <= {quo_q[lctmw_pkg::SUM_W-2:0], q_bit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== src/load_cell_trimmed_mean_weigher.sv =====
// Load-cell weigher: averages batches of converter readings, trimming the
// smallest and largest accepted weight of each batch.
// Input channel (in_valid/in_ready) carries raw_count and converter_ready.
// Output channel (out_valid/out_ready) carries one result per batch:
// average_weight (Q16.8 grams), result_valid and accepted_count.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready; write it only while the block is idle.
// One item at a time: a rejected reading (converter not ready or weight
// negative) goes straight to the accumulate step, an accepted one through
// the bit-serial 24 x 24 multiply. The item that closes a batch runs the
// bit-serial 32 / 8 divide of the trimmed sum when more than two weights
// were accepted.
// Results sit in an output register: the next reading is taken while a
// result waits, and only the next batch end stalls on a full register.
// Reset loads the register defaults and clears the batch accumulators.
module load_cell_trimmed_mean_weigher #(
	parameter int unsigned MAX_BATCH = lctmw_pkg::MAX_BATCH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [lctmw_pkg::RAW_W-1:0]      raw_count,
	input  logic                                    converter_ready,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [lctmw_pkg::WEIGHT_W-1:0]          average_weight,
	output logic                                    result_valid,
	output logic [lctmw_pkg::CNT_W-1:0]             accepted_count,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [lctmw_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [lctmw_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam logic [lctmw_pkg::CNT_W-1:0] BatchMax = lctmw_pkg::CNT_W'(MAX_BATCH);
	localparam logic [lctmw_pkg::CNT_W-1:0] BatchMin = lctmw_pkg::CNT_W'(lctmw_pkg::MIN_BATCH);
	localparam logic [lctmw_pkg::CNT_W-1:0] Two      = lctmw_pkg::CNT_W'(2);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CHK,
		ST_ACC,
		ST_END,
		ST_TRIM,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t                                state_q;

	// Configuration registers
	logic [lctmw_pkg::CNT_W-1:0]           batch_size_q;
	logic [lctmw_pkg::RAW_W-1:0]           zero_offset_q;
	logic [lctmw_pkg::GAIN_W-1:0]          gain_q;
	logic [lctmw_pkg::WEIGHT_W-1:0]        floor_q;
	logic [lctmw_pkg::WEIGHT_W-1:0]        ceiling_q;

	// Batch accumulators
	logic [lctmw_pkg::SUM_W-1:0]           sum_q;
	logic [lctmw_pkg::WEIGHT_W-1:0]        min_q;
	logic [lctmw_pkg::WEIGHT_W-1:0]        max_q;
	logic [lctmw_pkg::CNT_W-1:0]           valid_q;
	logic [lctmw_pkg::CNT_W-1:0]           seen_q;

	// Per-item working registers
	logic                                  keep_q;
	logic [lctmw_pkg::WEIGHT_W-1:0]        weight_q;
	logic [lctmw_pkg::SUM_W-1:0]           trim_q;
	logic [lctmw_pkg::WEIGHT_W-1:0]        avg_q;
	logic                                  ok_q;

	// Output register
	logic                                  out_valid_q;
	logic [lctmw_pkg::WEIGHT_W-1:0]        average_weight_q;
	logic                                  result_valid_q;
	logic [lctmw_pkg::CNT_W-1:0]           accepted_count_q;

	logic [lctmw_pkg::RAW_W:0]             diff;
	logic                                  sample_ok;
	logic                                  in_take;
	logic                                  mul_start;
	logic                                  mul_done;
	logic [lctmw_pkg::PROD_W-1:0]          mul_product;
	logic [lctmw_pkg::WEIGHT_W-1:0]        weight_sat;
	logic                                  div_start;
	logic                                  div_done;
	logic [lctmw_pkg::SUM_W-1:0]           div_quotient;
	logic [lctmw_pkg::SUM_W-1:0]           div_dividend;
	logic [lctmw_pkg::CNT_W-1:0]           div_divisor;
	logic [lctmw_pkg::CNT_W-1:0]           batch_eff;
	logic [lctmw_pkg::CNT_W-1:0]           seen_next;
	logic                                  batch_end;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_take   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Offset-corrected reading, exact in one extra bit
	assign diff = {raw_count[lctmw_pkg::RAW_W-1], raw_count}
		- {zero_offset_q[lctmw_pkg::RAW_W-1], zero_offset_q};
	assign sample_ok = converter_ready && !diff[lctmw_pkg::RAW_W];
	assign mul_start = in_take && sample_ok;

	lctmw_mul u_mul (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (mul_start),
		.multiplicand (gain_q),
		.multiplier   (diff[lctmw_pkg::DIFF_W-1:0]),
		.done         (mul_done),
		.product      (mul_product)
	);

	// Drop the low fraction bits, saturate at the top of the weight range
	assign weight_sat = (|mul_product[lctmw_pkg::PROD_W-1:lctmw_pkg::FRAC_DROP+lctmw_pkg::WEIGHT_W])
		? lctmw_pkg::WEIGHT_MAX
		: mul_product[lctmw_pkg::FRAC_DROP+lctmw_pkg::WEIGHT_W-1:lctmw_pkg::FRAC_DROP];

	// Clamp the batch size into the supported range
	always_comb begin
		if (batch_size_q < BatchMin) begin
			batch_eff = BatchMin;
		end else if (batch_size_q > BatchMax) begin
			batch_eff = BatchMax;
		end else begin
			batch_eff = batch_size_q;
		end
	end

	assign seen_next = seen_q + 1'b1;
	assign batch_end = (seen_next >= batch_eff);

	// Trimmed sum over the count of inner samples
	assign div_start    = (state_q == ST_TRIM);
	assign div_dividend = trim_q - lctmw_pkg::SUM_W'(max_q);
	assign div_divisor  = valid_q - Two;

	lctmw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_size_q  <= lctmw_pkg::BATCH_SIZE_RST;
			zero_offset_q <= lctmw_pkg::ZERO_OFFSET_RST;
			gain_q        <= lctmw_pkg::GAIN_RST;
			floor_q       <= lctmw_pkg::FLOOR_RST;
			ceiling_q     <= lctmw_pkg::WEIGHT_MAX;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lctmw_pkg::REG_BATCH_SIZE:  batch_size_q  <= cfg_data[lctmw_pkg::CNT_W-1:0];
				lctmw_pkg::REG_ZERO_OFFSET: zero_offset_q <= cfg_data[lctmw_pkg::RAW_W-1:0];
				lctmw_pkg::REG_GAIN:        gain_q        <= cfg_data[lctmw_pkg::GAIN_W-1:0];
				lctmw_pkg::REG_FLOOR:       floor_q       <= cfg_data[lctmw_pkg::WEIGHT_W-1:0];
				lctmw_pkg::REG_CEILING:     ceiling_q     <= cfg_data[lctmw_pkg::WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// Item sequencer, accumulators and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			sum_q            <= '0;
			min_q            <= lctmw_pkg::WEIGHT_MAX;
			max_q            <= '0;
			valid_q          <= '0;
			seen_q           <= '0;
			keep_q           <= 1'b0;
			weight_q         <= '0;
			trim_q           <= '0;
			avg_q            <= '0;
			ok_q             <= 1'b0;
			out_valid_q      <= 1'b0;
			average_weight_q <= '0;
			result_valid_q   <= 1'b0;
			accepted_count_q <= '0;
		end else begin
			// Drop the result once taken; in the emit state the refill decides
			if (out_valid_q && out_ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						keep_q  <= 1'b0;
						state_q <= sample_ok ? ST_MUL : ST_ACC;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					weight_q <= weight_sat;
					keep_q   <= (weight_sat >= floor_q) && (weight_sat <= ceiling_q);
					state_q  <= ST_ACC;
				end
				ST_ACC: begin
					if (keep_q) begin
						sum_q   <= sum_q + lctmw_pkg::SUM_W'(weight_q);
						valid_q <= valid_q + 1'b1;
						if (weight_q < min_q) begin
							min_q <= weight_q;
						end
						if (weight_q > max_q) begin
							max_q <= weight_q;
						end
					end
					seen_q  <= seen_next;
					state_q <= batch_end ? ST_END : ST_IDLE;
				end
				ST_END: begin
					if (valid_q == Two) begin
						avg_q   <= min_q;
						ok_q    <= 1'b1;
						state_q <= ST_EMIT;
					end else if (valid_q < Two) begin
						avg_q   <= '0;
						ok_q    <= 1'b0;
						state_q <= ST_EMIT;
					end else begin
						trim_q  <= sum_q - lctmw_pkg::SUM_W'(min_q);
						state_q <= ST_TRIM;
					end
				end
				ST_TRIM: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						avg_q   <= div_quotient[lctmw_pkg::WEIGHT_W-1:0];
						ok_q    <= 1'b1;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// Hold until the output register is free, then clear the batch
					if (!out_valid_q || out_ready) begin
						out_valid_q      <= 1'b1;
						average_weight_q <= avg_q;
						result_valid_q   <= ok_q;
						accepted_count_q <= valid_q;
						sum_q            <= '0;
						min_q            <= lctmw_pkg::WEIGHT_MAX;
						max_q            <= '0;
						valid_q          <= '0;
						seen_q           <= '0;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign average_weight = average_weight_q;
	assign result_valid   = result_valid_q;
	assign accepted_count = accepted_count_q;

`ifndef SYNTHESIS
	a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == ST_MUL)
		else $error("multiplier finished outside the multiply state");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_valid_le_seen: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q <= seen_q)
		else $error("more accepted samples than samples seen");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q != '0 |-> min_q <= max_q)
		else $error("batch minimum above batch maximum");

	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_valid_q |-> accepted_count_q >= Two)
		else $error("valid result with fewer than two accepted samples");
`endif

endmodule

// ===== bench/tb_load_cell_trimmed_mean_weigher.sv =====
module tb_load_cell_trimmed_mean_weigher;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RAW_W      = lctmw_pkg::RAW_W;
	localparam int unsigned WEIGHT_W   = lctmw_pkg::WEIGHT_W;
	localparam int unsigned GAIN_W     = lctmw_pkg::GAIN_W;
	localparam int unsigned PROD_W     = lctmw_pkg::PROD_W;
	localparam int unsigned FRAC_DROP  = lctmw_pkg::FRAC_DROP;
	localparam int unsigned SUM_W      = lctmw_pkg::SUM_W;
	localparam int unsigned CNT_W      = lctmw_pkg::CNT_W;
	localparam int unsigned CFG_IDX_W  = lctmw_pkg::CFG_IDX_W;
	localparam int unsigned CFG_DATA_W = lctmw_pkg::CFG_DATA_W;

	localparam int unsigned BATCH_LIMIT   = lctmw_pkg::MAX_BATCH_DEF;
	localparam int unsigned SETTLE_CYCLES = 100;
	localparam int unsigned HOLD_CYCLES   = 2000;
	localparam int unsigned CYCLE_LIMIT   = 1_000_000;
	localparam int unsigned PHASES        = 12;
	localparam int unsigned PHASE_ITEMS   = 80;
	localparam logic signed [RAW_W-1:0] RAW_MAX = {1'b0, {(RAW_W-1){1'b1}}};
	localparam logic signed [RAW_W-1:0] RAW_MIN = {1'b1, {(RAW_W-1){1'b0}}};
	localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_REG =
		CFG_IDX_W'(lctmw_pkg::REG_CEILING) + 1'b1;
	localparam logic [CFG_IDX_W-1:0] LAST_SPARE_REG  = '1;

	typedef struct packed {
		logic signed [RAW_W-1:0] raw;
		logic                    rdy;
	} reading_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] avg;
		logic                ok;
		logic [CNT_W-1:0]    count;
	} batch_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [RAW_W-1:0] raw_count = '0;
	logic converter_ready = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [WEIGHT_W-1:0] average_weight;
	logic result_valid;
	logic [CNT_W-1:0] accepted_count;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Calibration registers as the predictor sees them
	logic [CNT_W-1:0]    cal_batch   = lctmw_pkg::BATCH_SIZE_RST;
	logic [RAW_W-1:0]    cal_offset  = lctmw_pkg::ZERO_OFFSET_RST;
	logic [GAIN_W-1:0]   cal_gain    = lctmw_pkg::GAIN_RST;
	logic [WEIGHT_W-1:0] cal_floor   = lctmw_pkg::FLOOR_RST;
	logic [WEIGHT_W-1:0] cal_ceiling = lctmw_pkg::WEIGHT_MAX;

	// Batch accumulators
	logic [SUM_W-1:0]    batch_sum      = '0;
	logic [WEIGHT_W-1:0] batch_min      = lctmw_pkg::WEIGHT_MAX;
	logic [WEIGHT_W-1:0] batch_max      = '0;
	logic [CNT_W-1:0]    batch_accepted = '0;
	logic [CNT_W-1:0]    batch_seen     = '0;

	reading_t      readings_to_send[$];
	batch_result_t pending_results[$];
	reading_t      next_reading;
	batch_result_t predicted;
	batch_result_t oldest;

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned mismatches     = 0;
	bit          in_taken       = 1'b0;
	bit          hold_active    = 1'b0;
	event        hold_go;

	load_cell_trimmed_mean_weigher #(.MAX_BATCH(BATCH_LIMIT)) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.raw_count       (raw_count),
		.converter_ready (converter_ready),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.average_weight  (average_weight),
		.result_valid    (result_valid),
		.accepted_count  (accepted_count),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Convert one reading to a weight, fold it into the batch and report
	// the trimmed mean when the batch closes
	function automatic bit weigh_reading(input logic signed [RAW_W-1:0] raw,
			input logic rdy, output batch_result_t res);
		logic [RAW_W:0]                  diff;
		logic [PROD_W-1:0]               prod;
		logic [PROD_W-FRAC_DROP-1:0]     scaled;
		logic [WEIGHT_W-1:0]             w;
		logic [CNT_W-1:0]                eff;
		logic [SUM_W-1:0]                trimmed;
		res = '0;
		diff = {raw[RAW_W-1], raw} - {cal_offset[RAW_W-1], cal_offset};
		if (rdy && !diff[RAW_W]) begin
			prod = PROD_W'(diff[RAW_W-1:0]) * PROD_W'(cal_gain);
			scaled = prod[PROD_W-1:FRAC_DROP];
			w = (|scaled[PROD_W-FRAC_DROP-1:WEIGHT_W]) ? lctmw_pkg::WEIGHT_MAX
				: scaled[WEIGHT_W-1:0];
			if (w >= cal_floor && w <= cal_ceiling) begin
				batch_sum = batch_sum + SUM_W'(w);
				if (w < batch_min)
					batch_min = w;
				if (w > batch_max)
					batch_max = w;
				batch_accepted = batch_accepted + 1'b1;
			end
		end
		batch_seen = batch_seen + 1'b1;
		eff = cal_batch;
		if (eff < lctmw_pkg::MIN_BATCH)
			eff = CNT_W'(lctmw_pkg::MIN_BATCH);
		if (eff > BATCH_LIMIT)
			eff = CNT_W'(BATCH_LIMIT);
		if (batch_seen < eff)
			return 1'b0;
		res.count = batch_accepted;
		if (batch_accepted == 2) begin
			res.avg = batch_min;
			res.ok = 1'b1;
		end else if (batch_accepted > 2) begin
			trimmed = batch_sum - SUM_W'(batch_min) - SUM_W'(batch_max);
			res.avg = WEIGHT_W'(trimmed / SUM_W'(batch_accepted - 2'd2));
			res.ok = 1'b1;
		end
		batch_sum = '0;
		batch_min = lctmw_pkg::WEIGHT_MAX;
		batch_max = '0;
		batch_accepted = '0;
		batch_seen = '0;
		return 1'b1;
	endfunction

	// Feed readings: hold the item until it is taken, then advance or idle
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (readings_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_reading = readings_to_send.pop_front();
				in_valid <= 1'b1;
				raw_count <= next_reading.raw;
				converter_ready <= next_reading.rdy;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the result side at random, or fully while a hold-off runs
	always @(negedge clk) begin
		out_ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
	end

	// Long hold-off of the result side, counted here in cycles
	always begin
		@(hold_go);
		hold_active = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active = 1'b0;
	end

	// Predict on every taken reading, check every delivered result
	always @(posedge clk) begin
		in_taken = arst_n && in_valid && in_ready;
		if (in_taken) begin
			if (weigh_reading(raw_count, converter_ready, predicted))
				pending_results.push_back(predicted);
		end
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no batch pending: average_weight %0d", average_weight);
				mismatches++;
			end else begin
				oldest = pending_results.pop_front();
				if (average_weight !== oldest.avg) begin
					$error("average_weight: expected %0d, got %0d", oldest.avg, average_weight);
					mismatches++;
				end
				if (result_valid !== oldest.ok) begin
					$error("result_valid: expected %0d, got %0d", oldest.ok, result_valid);
					mismatches++;
				end
				if (accepted_count !== oldest.count) begin
					$error("accepted_count: expected %0d, got %0d", oldest.count,
						accepted_count);
					mismatches++;
				end
			end
		end
	end

	// Give up on a hung run
	initial begin
		for (int unsigned n = 0; n < CYCLE_LIMIT; n++)
			@(posedge clk);
		$display("load_cell_trimmed_mean_weigher: mismatch");
		$finish;
	end

	task automatic add_reading(input logic signed [RAW_W-1:0] raw, input logic rdy);
		readings_to_send.push_back('{raw: raw, rdy: rdy});
	endtask

	// Wait until every item is taken and every result is out, then let a
	// half-finished reading run out inside the block
	task automatic drain_and_settle();
		while (readings_to_send.size() != 0 || in_valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			lctmw_pkg::REG_BATCH_SIZE:  cal_batch = data[CNT_W-1:0];
			lctmw_pkg::REG_ZERO_OFFSET: cal_offset = data[RAW_W-1:0];
			lctmw_pkg::REG_GAIN:        cal_gain = data[GAIN_W-1:0];
			lctmw_pkg::REG_FLOOR:       cal_floor = data[WEIGHT_W-1:0];
			lctmw_pkg::REG_CEILING:     cal_ceiling = data[WEIGHT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly plausible tray readings a little above the zero point, plus noise
	task automatic queue_readings(input int unsigned n);
		logic [RAW_W-1:0] delta;
		int unsigned      k;
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(99) < 75) begin
				k = $urandom_range(0, RAW_W);
				delta = RAW_W'($urandom) & ((RAW_W'(1) << k) - 1'b1);
				add_reading(cal_offset + delta, $urandom_range(19) != 0);
			end else begin
				add_reading(RAW_W'($urandom), 1'($urandom_range(1)));
			end
		end
	endtask

	// Choose calibration for one random phase and load it
	task automatic load_settings(input int unsigned phase);
		logic [CFG_DATA_W-1:0] bs;
		logic [CFG_DATA_W-1:0] off;
		logic [CFG_DATA_W-1:0] gn;
		logic [CFG_DATA_W-1:0] fl;
		logic [CFG_DATA_W-1:0] cl;
		if (phase == 0) begin
			bs = CFG_DATA_W'(lctmw_pkg::MIN_BATCH);
			off = lctmw_pkg::ZERO_OFFSET_RST;
			gn = lctmw_pkg::GAIN_RST;
			fl = lctmw_pkg::FLOOR_RST;
			cl = lctmw_pkg::WEIGHT_MAX;
		end else if (phase == 1) begin
			// full batch at full gain from the lowest zero point: many weights saturate
			bs = CFG_DATA_W'(BATCH_LIMIT);
			off = RAW_MIN;
			gn = '1;
			fl = '0;
			cl = lctmw_pkg::WEIGHT_MAX;
		end else begin
			case ($urandom_range(9))
				0: bs = CFG_DATA_W'($urandom_range(0, lctmw_pkg::MIN_BATCH - 1));
				1: bs = CFG_DATA_W'($urandom_range(17, 40));
				default: bs = CFG_DATA_W'($urandom_range(lctmw_pkg::MIN_BATCH, 16));
			endcase
			case ($urandom_range(5))
				0: off = RAW_MIN;
				1: off = RAW_MAX;
				default: off = CFG_DATA_W'($urandom);
			endcase
			if (phase == 3)
				gn = '0;
			else if (phase == 5)
				gn = '1;
			else
				gn = CFG_DATA_W'($urandom >> $urandom_range(8, 20));
			if ($urandom_range(2) == 0)
				fl = '0;
			else
				fl = CFG_DATA_W'($urandom_range(0, 1 << $urandom_range(0, 22)));
			case ($urandom_range(7))
				0, 1, 2, 3: cl = lctmw_pkg::WEIGHT_MAX;
				4: cl = fl >> 1;
				default: cl = (fl > lctmw_pkg::WEIGHT_MAX - 24'(1 << 23))
					? lctmw_pkg::WEIGHT_MAX
					: fl + CFG_DATA_W'($urandom_range(0, 1 << $urandom_range(4, 22)));
			endcase
		end
		write_reg(lctmw_pkg::REG_BATCH_SIZE, bs);
		write_reg(lctmw_pkg::REG_ZERO_OFFSET, off);
		write_reg(lctmw_pkg::REG_GAIN, gn);
		write_reg(lctmw_pkg::REG_FLOOR, fl);
		write_reg(lctmw_pkg::REG_CEILING, cl);
		// spare indexes must leave every register alone
		write_reg(CFG_IDX_W'($urandom_range(FIRST_SPARE_REG, LAST_SPARE_REG)),
			CFG_DATA_W'($urandom));
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset calibration: extremes of the reading, rejects and a zero weight
		add_reading(RAW_MAX, 1'b1);
		add_reading(RAW_MIN, 1'b1);
		add_reading(24'sd0, 1'b1);
		add_reading(24'sd1, 1'b1);
		add_reading(RAW_MAX, 1'b0);
		add_reading(-24'sd1, 1'b1);
		add_reading(24'sd100000, 1'b1);
		add_reading(24'sd4000000, 1'b1);
		add_reading(24'sd0, 1'b0);
		add_reading(24'sd2000000, 1'b1);
		drain_and_settle();

		// Batch size below the minimum; exactly two weights accepted
		write_reg(lctmw_pkg::REG_BATCH_SIZE, '0);
		add_reading(24'sd1000, 1'b1);
		add_reading(24'sd0, 1'b0);
		add_reading(24'sd5000, 1'b1);
		drain_and_settle();

		// Nothing accepted
		write_reg(lctmw_pkg::REG_BATCH_SIZE, CFG_DATA_W'(1));
		add_reading(RAW_MIN, 1'b1);
		add_reading(24'sd12345, 1'b0);
		add_reading(-24'sd5, 1'b1);
		drain_and_settle();

		// Full gain from the lowest zero point: weights saturate
		write_reg(lctmw_pkg::REG_BATCH_SIZE, CFG_DATA_W'(2));
		write_reg(lctmw_pkg::REG_GAIN, '1);
		write_reg(lctmw_pkg::REG_ZERO_OFFSET, RAW_MIN);
		add_reading(RAW_MAX, 1'b1);
		add_reading(RAW_MAX, 1'b1);
		add_reading(RAW_MIN, 1'b1);
		drain_and_settle();

		// Floor above ceiling, then shrink the batch while it is partly full
		write_reg(lctmw_pkg::REG_GAIN, lctmw_pkg::GAIN_RST);
		write_reg(lctmw_pkg::REG_ZERO_OFFSET, lctmw_pkg::ZERO_OFFSET_RST);
		write_reg(lctmw_pkg::REG_BATCH_SIZE, CFG_DATA_W'(5));
		write_reg(lctmw_pkg::REG_FLOOR, CFG_DATA_W'(1000));
		write_reg(lctmw_pkg::REG_CEILING, CFG_DATA_W'(10));
		add_reading(RAW_MAX, 1'b1);
		add_reading(24'sd5000, 1'b1);
		add_reading(24'sd0, 1'b1);
		add_reading(RAW_MIN, 1'b0);
		drain_and_settle();
		write_reg(lctmw_pkg::REG_BATCH_SIZE, CFG_DATA_W'(lctmw_pkg::MIN_BATCH));
		add_reading(24'sd2000, 1'b1);
		drain_and_settle();

		// Random phases, each with its own calibration and flow pattern
		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			load_settings(phase);
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 81;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 81;
				end
				default: begin
					send_idle_pct = 27;
					recv_stall_pct = 27;
				end
			endcase
			if (phase == 0)
				-> hold_go;
			queue_readings(phase == 1 ? BATCH_LIMIT : PHASE_ITEMS);
			drain_and_settle();
		end

		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("load_cell_trimmed_mean_weigher: match");
		end else begin
			$display("load_cell_trimmed_mean_weigher: mismatch");
		end
		$finish;
	end

endmodule
